// ===== design/grc_pkg.sv =====
// Shared types and constants for the grid raycast column block.
package grc_pkg;

	localparam int DEF_SCREEN_WIDTH  = 420;
	localparam int DEF_SCREEN_HEIGHT = 308;
	localparam int DEF_MAP_SIZE      = 16;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 12;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PLAYER_X   = 3'd0,
		REG_PLAYER_Y   = 3'd1,
		REG_ANGLE      = 3'd2,
		REG_FOV        = 3'd3,
		REG_DEPTH      = 3'd4
	} cfg_reg_t;

	localparam logic        ACT_LOAD = 1'b0;
	localparam logic        ACT_CAST = 1'b1;

	typedef enum logic [3:0] {
		S_IDLE, S_ANG, S_ANG_MUL, S_SIN, S_SIN_DIV, S_COS, S_COS_DIV,
		S_XS, S_YS, S_MARCH, S_CEIL, S_CEIL_DIV, S_FIN
	} state_t;

	typedef struct packed {
		logic load_take;
		logic cast_take;
		logic ang_init;
		logic ang_quo;
		logic sin_init;
		logic cos_init;
		logic xs_init;
		logic div_step;
		logic march_init;
		logic march_step;
		logic ceil_init;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic div_last;
		logic march_stop;
		logic out_busy;
	} sts_t;

endpackage

// ===== design/grc_ctrl.sv =====
// Sequencer for load and cast items.
module grc_ctrl import grc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic action,
	output logic in_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid && action == ACT_CAST) state_d = S_ANG;
			end
			S_ANG:      state_d = S_ANG_MUL;
			S_ANG_MUL:  state_d = S_SIN;
			S_SIN:      state_d = S_SIN_DIV;
			S_SIN_DIV:  if (sts.div_last) state_d = S_COS;
			S_COS:      state_d = S_COS_DIV;
			S_COS_DIV:  if (sts.div_last) state_d = S_XS;
			S_XS:       state_d = S_YS;
			S_YS:       state_d = S_MARCH;
			S_MARCH:    if (sts.march_stop) state_d = S_CEIL;
			S_CEIL:     state_d = S_CEIL_DIV;
			S_CEIL_DIV: if (sts.div_last) state_d = S_FIN;
			S_FIN:      if (!sts.out_busy) state_d = S_IDLE;
			default:    state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_stall = 1'b1;
		case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				cmd.load_take = in_valid && action == ACT_LOAD;
				cmd.cast_take = in_valid && action == ACT_CAST;
			end
			S_ANG:     cmd.ang_init = 1'b1;
			S_ANG_MUL: cmd.ang_quo = 1'b1;
			S_SIN:     cmd.sin_init = 1'b1;
			S_COS:     cmd.cos_init = 1'b1;
			S_XS:      cmd.xs_init = 1'b1;
			S_YS:      cmd.march_init = 1'b1;
			S_SIN_DIV, S_COS_DIV, S_CEIL_DIV: cmd.div_step = 1'b1;
			S_MARCH: cmd.march_step = !sts.march_stop;
			S_CEIL: cmd.ceil_init = 1'b1;
			S_FIN:  cmd.out_load = !sts.out_busy;
			default: ;
		endcase
	end

endmodule

// ===== design/grc_dp.sv =====
// Datapath: config registers, wall map, shared divider, ray march, output register.
module grc_dp import grc_pkg::*; #(
	parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
	parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT,
	parameter int MAP_SIZE      = DEF_MAP_SIZE
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data,
	input  logic [3:0]           row_index,
	input  logic [15:0]          row_walls,
	input  logic [8:0]           column,
	input  cmd_t                 cmd,
	output sts_t                 sts,
	input  logic                 out_stall,
	output logic                 out_valid,
	output logic [8:0]           column_out,
	output logic [7:0]           distance_steps,
	output logic                 wall_hit,
	output logic signed [12:0]   ceiling_row,
	output logic [11:0]          floor_row
);

	localparam int MW = (MAP_SIZE > 1) ? $clog2(MAP_SIZE) : 1;
	localparam int HW = $clog2(SCREEN_HEIGHT + 1);
	localparam int PW = HW + 8;
	localparam int NW = 22;
	localparam int RW = 24;
	// column*fov / SCREEN_WIDTH by reciprocal, exact for products below 2^21
	localparam int ASH = 21 + $clog2(SCREEN_WIDTH);
	localparam logic [63:0] ARECIP =
		((64'd1 << ASH) + 64'(SCREEN_WIDTH) - 64'd1) / 64'(SCREEN_WIDTH);

	// magnitude / 640 as {quotient, remainder}; 640 = 128 * 5, x/5 = (x*205) >> 10
	function automatic logic [14:0] split_640(input logic [14:0] m);
		logic [15:0] p;
		logic [4:0]  q;
		p = 16'(m[14:7]) * 16'd205;
		q = p[14:10];
		return {q, 10'(m - 15'(q) * 15'd640)};
	endfunction

	logic [11:0] px_q, py_q, pa_q, fov_q;
	logic [7:0]  depth_q;
	logic [15:0] map_q [MAP_SIZE];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			px_q    <= 12'd2048;
			py_q    <= 12'd2048;
			pa_q    <= 12'd3584;
			fov_q   <= 12'd512;
			depth_q <= 8'd160;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_PLAYER_X: px_q    <= cfg_data;
				REG_PLAYER_Y: py_q    <= cfg_data;
				REG_ANGLE:    pa_q    <= cfg_data;
				REG_FOV:      fov_q   <= cfg_data;
				REG_DEPTH:    depth_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_take && 32'(row_index) < MAP_SIZE) map_q[MW'(row_index)] <= row_walls;
	end

	// shared restoring divider
	logic [RW-1:0] dr_q, dd_q, rs;
	logic [NW-1:0] dn_q, dq_q;
	logic [4:0]    dc_q;
	logic          ge;

	assign rs = {dr_q[RW-2:0], dn_q[NW-1]};
	assign ge = rs >= dd_q;

	logic [8:0]  col_q;
	logic [20:0] prod_q;
	logic [44:0] aprod_c;
	logic [11:0] aq_q;
	logic [11:0] ang_q, ang_c, cang;
	logic [10:0] tq;
	logic [21:0] t_c;
	logic [20:0] prod_c;
	logic [14:0] smag_q, cmag_q, ysplit;
	logic        sneg_q, cneg_q, ceil_neg_q, hit_q;
	logic [4:0]  ax_q, ay_q;
	logic [9:0]  bx_q, by_q;
	logic [15:0] qx_q, qy_q;
	logic [10:0] rx_q, ry_q, rx_n, ry_n;
	logic [7:0]  k_q, ad;
	logic [PW-1:0] hprod;
	logic        wall;

	assign aprod_c = 45'(prod_q) * 45'(ARECIP[22:0]);
	assign ang_c  = pa_q - (fov_q >> 1) + aq_q;
	assign cang   = ang_q + 12'd1024;
	assign tq     = cmd.sin_init ? ang_c[10:0] : cang[10:0];
	assign t_c    = 22'(tq) * (22'd2048 - 22'(tq));
	assign prod_c = 21'(col_q) * 21'(fov_q);
	assign ysplit = split_640(cmag_q);
	assign ad     = (k_q < 8'd20) ? 8'd20 - k_q : k_q - 8'd20;
	assign hprod  = PW'(SCREEN_HEIGHT) * PW'(ad);
	assign rx_n   = rx_q + 11'(bx_q);
	assign ry_n   = ry_q + 11'(by_q);

	always_ff @(posedge clk) begin
		if (cmd.cast_take) col_q <= column;
		if (cmd.ang_init) prod_q <= prod_c;
		if (cmd.ang_quo) aq_q <= aprod_c[ASH +: 12];
		if (cmd.sin_init || cmd.cos_init) begin
			dr_q <= RW'(t_c) << 1;
			dd_q <= 24'd5242880 - RW'(t_c);
			dn_q <= '0;
			dq_q <= '0;
			dc_q <= 5'd15;
		end else if (cmd.ceil_init) begin
			dr_q <= '0;
			dd_q <= RW'({k_q, 1'b0});
			dn_q <= NW'(hprod) << (NW - PW);
			dq_q <= '0;
			dc_q <= 5'(PW);
		end else if (cmd.div_step) begin
			dr_q <= ge ? rs - dd_q : rs;
			dq_q <= {dq_q[NW-2:0], ge};
			dn_q <= dn_q << 1;
			dc_q <= dc_q - 5'd1;
		end
		if (cmd.sin_init) begin
			ang_q  <= ang_c;
			sneg_q <= ang_c[11];
		end
		if (cmd.cos_init) begin
			smag_q <= dq_q[14:0];
			cneg_q <= cang[11];
		end
		if (cmd.xs_init) begin
			cmag_q       <= dq_q[14:0];
			{ax_q, bx_q} <= split_640(smag_q);
		end
		if (cmd.march_init) begin
			{ay_q, by_q} <= ysplit;
		end
		if (cmd.ceil_init) begin
			ceil_neg_q <= k_q < 8'd20;
			hit_q      <= wall;
		end
	end

	// march position registers
	logic signed [15:0] offx, offy, posx, posy;
	logic [7:0] cx, cy;

	always_ff @(posedge clk) begin
		if (cmd.march_init) begin
			k_q  <= 8'd1;
			qx_q <= 16'(ax_q);
			rx_q <= 11'(bx_q);
			qy_q <= 16'(ysplit[14:10]);
			ry_q <= 11'(ysplit[9:0]);
		end else if (cmd.march_step) begin
			k_q  <= k_q + 8'd1;
			qx_q <= qx_q + 16'(ax_q) + 16'(rx_n >= 11'd640);
			rx_q <= (rx_n >= 11'd640) ? rx_n - 11'd640 : rx_n;
			qy_q <= qy_q + 16'(ay_q) + 16'(ry_n >= 11'd640);
			ry_q <= (ry_n >= 11'd640) ? ry_n - 11'd640 : ry_n;
		end
	end

	always_comb begin
		offx = sneg_q ? -$signed(qx_q) : $signed(qx_q);
		offy = cneg_q ? -$signed(qy_q) : $signed(qy_q);
		posx = $signed({4'd0, px_q}) + offx;
		posy = $signed({4'd0, py_q}) + offy;
		cx = posx[15:8];
		cy = posy[15:8];
		if (posx < 0 || posy < 0) wall = 1'b1;
		else if (32'(cx) >= MAP_SIZE || 32'(cy) >= MAP_SIZE) wall = 1'b1;
		else if (cx >= 8'd16) wall = 1'b0;
		else wall = map_q[MW'(cy)][cx[3:0]];
	end

	logic signed [22:0] ceil_v, floor_v;
	assign ceil_v  = ceil_neg_q ? -$signed({1'b0, dq_q}) : $signed({1'b0, dq_q});
	assign floor_v = 23'(SCREEN_HEIGHT) - ceil_v;

	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			column_out     <= col_q;
			distance_steps <= k_q;
			wall_hit       <= hit_q;
			ceiling_row    <= ceil_v[12:0];
			floor_row      <= floor_v[11:0];
		end
	end

	assign out_valid      = out_valid_q;
	assign sts.div_last   = dc_q == 5'd1;
	assign sts.march_stop = wall || k_q >= depth_q;
	assign sts.out_busy   = out_valid_q && out_stall;

endmodule

// ===== design/grid_raycast_column_top.sv =====
// Per cast item, from input accept to out_valid: angle setup and multiply, sine divide,
// cosine divide, step setup, k march steps (k = 1..REG_DEPTH value), ceiling divide and
// output load; longer while the output is stalled. Throughput: one item in flight; a
// cast item finishes before the next item is taken, load items are taken while idle.
// Reset: arst_n resets control and configuration to defaults; the wall map is not cleared.
module grid_raycast_column_top import grc_pkg::*; #(
	parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
	parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT,
	parameter int MAP_SIZE      = DEF_MAP_SIZE
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 action,
	input  logic [3:0]           row_index,
	input  logic [15:0]          row_walls,
	input  logic [8:0]           column,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [8:0]           column_out,
	output logic [7:0]           distance_steps,
	output logic                 wall_hit,
	output logic signed [12:0]   ceiling_row,
	output logic [11:0]          floor_row
);

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	grc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.action   (action),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	grc_dp #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT),
		.MAP_SIZE      (MAP_SIZE)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.row_index      (row_index),
		.row_walls      (row_walls),
		.column         (column),
		.cmd            (cmd),
		.sts            (sts),
		.out_stall      (out_stall),
		.out_valid      (out_valid),
		.column_out     (column_out),
		.distance_steps (distance_steps),
		.wall_hit       (wall_hit),
		.ceiling_row    (ceiling_row),
		.floor_row      (floor_row)
	);

endmodule
